FILE: src/cst_pkg.sv
// Shared types, codes and constants of the two-pass contrast stretch.
`timescale 1ns / 1ps

package cst_pkg;

	// Default width of the measured minimum and maximum.
	localparam int unsigned SAMPLE_BITS_DEF = 8;

	// Fixed field widths.
	localparam int unsigned IN_BITS    = 8;
	localparam int unsigned OUT_BITS   = 8;
	localparam int unsigned CFG_INDEX_BITS = 4;
	localparam int unsigned CFG_DATA_BITS  = 8;

	// Entries in the queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Reset values of the configuration registers.
	localparam logic [OUT_BITS-1:0] OUT_LOW_RESET  = 8'd0;
	localparam logic [OUT_BITS-1:0] OUT_HIGH_RESET = 8'd255;

	// Register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_LOW  = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_HIGH = 4'd1;

	// Operation codes of an input word.
	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_MAP     = 1'b1;

	typedef struct packed {
		logic                op;
		logic [IN_BITS-1:0]  sample;
		logic                first;
	} item_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] stretched;
		logic                degenerate;
	} result_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LOAD,
		BK_DIV,
		BK_FIN
	} back_state_t;

endpackage

FILE: src/cst_queue.sv
// Small register queue that carries map words from the front to the back.
`timescale 1ns / 1ps

module cst_queue #(
	parameter int unsigned WIDTH = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             head_valid
);

	localparam int unsigned DEPTH = cst_pkg::QUEUE_DEPTH;
	localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/cst_front.sv
// Front end: takes input words, tracks the measured range and queues map words.
`timescale 1ns / 1ps

module cst_front #(
	parameter int unsigned SAMPLE_BITS = cst_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  cst_pkg::item_t                                 item,
	input  logic                                           item_valid,
	output logic                                           item_ready,
	input  logic                                           q_full,
	output logic                                           push,
	output logic [cst_pkg::IN_BITS+2*SAMPLE_BITS-1:0]      push_data
);

	logic [SAMPLE_BITS-1:0] lo_seen_q;
	logic [SAMPLE_BITS-1:0] hi_seen_q;
	logic [SAMPLE_BITS-1:0] sample_ext;
	logic                   accept;

	// Measure words never enter the queue, so only map words wait for space.
	assign item_ready = !q_full || (item.op == cst_pkg::OP_MEASURE);
	assign accept     = item_valid && item_ready;
	assign sample_ext = SAMPLE_BITS'(item.sample);

	// A map word carries the range as it stands now, so later measure words
	// cannot disturb a word that still waits in the queue.
	assign push      = accept && (item.op == cst_pkg::OP_MAP);
	assign push_data = {item.sample, lo_seen_q, hi_seen_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_seen_q <= '1;
			hi_seen_q <= '0;
		end else if (accept && (item.op == cst_pkg::OP_MEASURE)) begin
			if (item.first) begin
				lo_seen_q <= sample_ext;
				hi_seen_q <= sample_ext;
			end else begin
				if (sample_ext < lo_seen_q) begin
					lo_seen_q <= sample_ext;
				end
				if (sample_ext > hi_seen_q) begin
					hi_seen_q <= sample_ext;
				end
			end
		end
	end

endmodule

FILE: src/cst_back.sv
// Back end: multiply, restoring divide, offset and clamp of one map word.
`timescale 1ns / 1ps

module cst_back #(
	parameter int unsigned SAMPLE_BITS = cst_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic [cst_pkg::IN_BITS+2*SAMPLE_BITS-1:0] head,
	input  logic                                      head_valid,
	output logic                                      pop,
	input  logic [cst_pkg::OUT_BITS-1:0]              out_low,
	input  logic [cst_pkg::OUT_BITS-1:0]              out_high,
	output cst_pkg::result_t                          result,
	output logic                                      result_valid,
	input  logic                                      result_ready
);

	localparam int unsigned SB = SAMPLE_BITS;
	localparam int unsigned OB = cst_pkg::OUT_BITS;
	localparam int unsigned QB = cst_pkg::OUT_BITS;
	localparam int unsigned PB = OB + SB;
	localparam int unsigned CB = $clog2(QB);

	cst_pkg::back_state_t state_q;
	cst_pkg::back_state_t state_d;

	// Fields of the queue head.
	logic [cst_pkg::IN_BITS-1:0] h_sample;
	logic [SB-1:0]               h_lo;
	logic [SB-1:0]               h_hi;

	logic [SB:0]   span_now;
	logic          degen_now;
	logic [SB:0]   dv;
	logic [SB:0]   dv_neg;
	logic [SB-1:0] dv_mag;
	logic [OB:0]   dout;
	logic [OB:0]   dout_neg;
	logic [OB-1:0] dout_mag;
	logic [PB-1:0] prod_now;

	logic [PB-1:0] prod_q;
	logic [SB-1:0] span_q;
	logic          neg_q;
	logic          degen_q;
	logic [SB-1:0] rem_q;
	logic          sat_q;
	logic [QB-1:0] pl_q;
	logic [QB-1:0] qt_q;
	logic [CB-1:0] cnt_q;
	logic          sat_now;

	logic [SB:0]   trial;
	logic [SB:0]   trial_sub;
	logic          trial_ge;

	logic [QB:0]   qmag;
	logic [OB+1:0] r_full;
	logic [OB-1:0] bmin;
	logic [OB-1:0] bmax;
	logic [OB-1:0] clamped;
	logic          out_load;

	cst_pkg::result_t result_q;
	logic             res_valid_q;

	assign h_sample = head[cst_pkg::IN_BITS+2*SB-1 -: cst_pkg::IN_BITS];
	assign h_lo     = head[2*SB-1:SB];
	assign h_hi     = head[SB-1:0];

	// An empty or inverted measured range gives the degenerate result.
	assign span_now  = {1'b0, h_hi} - {1'b0, h_lo};
	assign degen_now = span_now[SB] || (span_now == '0);

	// Signed operands are split into magnitude and sign for an unsigned multiply.
	assign dv       = {1'b0, SB'(h_sample)} - {1'b0, h_lo};
	assign dv_neg   = -dv;
	assign dv_mag   = dv[SB] ? dv_neg[SB-1:0] : dv[SB-1:0];
	assign dout     = {1'b0, out_high} - {1'b0, out_low};
	assign dout_neg = -dout;
	assign dout_mag = dout[OB] ? dout_neg[OB-1:0] : dout[OB-1:0];
	assign prod_now = PB'(dout_mag) * PB'(dv_mag);

	// A quotient of 256 or more always lands on a clamp bound, so the divider
	// only produces eight bits and flags the rest as saturated.
	assign sat_now = (prod_q[PB-1:QB] >= span_q);

	assign trial     = {rem_q, pl_q[QB-1]};
	assign trial_ge  = (trial >= {1'b0, span_q});
	assign trial_sub = trial - {1'b0, span_q};

	assign qmag   = sat_q ? {1'b1, {QB{1'b0}}} : {1'b0, qt_q};
	assign r_full = neg_q ? ({2'b00, out_low} - (OB+2)'(qmag))
	                      : ({2'b00, out_low} + (OB+2)'(qmag));
	assign bmin   = (out_low < out_high) ? out_low : out_high;
	assign bmax   = (out_low < out_high) ? out_high : out_low;

	always_comb begin
		if ($signed(r_full) < $signed({2'b00, bmin})) begin
			clamped = bmin;
		end else if ($signed(r_full) > $signed({2'b00, bmax})) begin
			clamped = bmax;
		end else begin
			clamped = r_full[OB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cst_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			cst_pkg::BK_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					state_d = degen_now ? cst_pkg::BK_FIN : cst_pkg::BK_LOAD;
				end
			end
			cst_pkg::BK_LOAD: begin
				state_d = sat_now ? cst_pkg::BK_FIN : cst_pkg::BK_DIV;
			end
			cst_pkg::BK_DIV: begin
				if (cnt_q == CB'(QB - 1)) begin
					state_d = cst_pkg::BK_FIN;
				end
			end
			cst_pkg::BK_FIN: begin
				if (!res_valid_q || result_ready) begin
					out_load = 1'b1;
					state_d  = cst_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = cst_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_q  <= prod_now;
			span_q  <= span_now[SB-1:0];
			neg_q   <= dv[SB] ^ dout[OB];
			degen_q <= degen_now;
		end
		if (state_q == cst_pkg::BK_LOAD) begin
			rem_q <= prod_q[PB-1:QB];
			sat_q <= sat_now;
			pl_q  <= prod_q[QB-1:0];
			qt_q  <= '0;
			cnt_q <= '0;
		end else if (state_q == cst_pkg::BK_DIV) begin
			rem_q <= trial_ge ? trial_sub[SB-1:0] : trial[SB-1:0];
			qt_q  <= {qt_q[QB-2:0], trial_ge};
			pl_q  <= {pl_q[QB-2:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
		if (out_load) begin
			result_q.stretched  <= degen_q ? out_low : clamped;
			result_q.degenerate <= degen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result       = result_q;
	assign result_valid = res_valid_q;

	// The back end never takes a word from an empty queue.
	a_pop_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("back end popped an empty queue");

	// The divider runs its full count before finishing.
	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cst_pkg::BK_DIV) && (cnt_q != CB'(QB - 1)) |=>
		(state_q == cst_pkg::BK_DIV))
		else $error("divider left early");

	// A degenerate result is the lower output bound register.
	a_degen_low: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && result_q.degenerate |-> (result_q.stretched == out_low))
		else $error("degenerate result differs from out_low");

	// Every other result lies inside the configured output range.
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result_q.degenerate |->
		((result_q.stretched >= out_low) && (result_q.stretched <= out_high)) ||
		((result_q.stretched >= out_high) && (result_q.stretched <= out_low)))
		else $error("result outside the output range");

endmodule

FILE: src/contrast_stretch_two_pass.sv
// Top level of the two-pass linear contrast stretch.
`timescale 1ns / 1ps

// Two-pass linear contrast stretch. Stream every channel sample of a frame
// once as a measure word (op = 0, first = 1 on the frame's first sample) to
// collect the minimum and maximum, then stream the samples again as map
// words (op = 1); each map word yields one result word holding
// (out_high - out_low) * (v - min) / (max - min) + out_low, truncated toward
// zero and clamped to the output range. When max is not above min (also
// right after reset) the result is out_low with degenerate set. A measure
// word gives no result. A map word is handed to the back end through a
// two-entry queue and passes there through these steps: read the queue and
// multiply, load the divider, eight steps of the radix-2 restoring divider
// that forms the 8-bit quotient, and add, clamp and load the output
// register; a degenerate word or one whose quotient saturates skips the
// divider. The divider is the only shared unit; the back end takes the next
// map word only after the last one has loaded the output register.
// Configuration (out_low at index 0, out_high at index 1, other indexes
// ignored) must be written through the cfg port only while the block is
// idle; the block itself does not enforce this, and cfg_ready is always high.
module contrast_stretch_two_pass #(
	parameter int unsigned SAMPLE_BITS = cst_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cst_pkg::item_t                       item,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	output cst_pkg::result_t                     result,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cst_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [cst_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	// Each queued word holds the sample and the range measured so far.
	localparam int unsigned QW = cst_pkg::IN_BITS + 2 * SAMPLE_BITS;

	logic [cst_pkg::OUT_BITS-1:0] out_low_q;
	logic [cst_pkg::OUT_BITS-1:0] out_high_q;

	logic          q_full;
	logic          q_push;
	logic [QW-1:0] q_push_data;
	logic          q_pop;
	logic [QW-1:0] q_head;
	logic          q_head_valid;

	// Configuration writes are always taken; unknown indexes do nothing.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_low_q  <= cst_pkg::OUT_LOW_RESET;
			out_high_q <= cst_pkg::OUT_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == cst_pkg::REG_OUT_LOW) begin
				out_low_q <= cfg_data[cst_pkg::OUT_BITS-1:0];
			end else if (cfg_index == cst_pkg::REG_OUT_HIGH) begin
				out_high_q <= cfg_data[cst_pkg::OUT_BITS-1:0];
			end
		end
	end

	// Front end: range tracking and queuing of map words.
	cst_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.q_full     (q_full),
		.push       (q_push),
		.push_data  (q_push_data)
	);

	// The queue lets the front keep taking words while the divider works.
	cst_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.head_valid (q_head_valid)
	);

	// Back end: arithmetic and the output register.
	cst_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.head_valid   (q_head_valid),
		.pop          (q_pop),
		.out_low      (out_low_q),
		.out_high     (out_high_q),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the two-pass contrast stretch block.
`timescale 1ns / 1ps

// The bench streams measure and map words into the block, predicts every
// result word in its own copy of the running minimum, maximum and output
// range, and compares each result word field by field in arrival order.
// Configuration is only written while the block is idle. That means after
// reset, or once every expected result word has arrived and the block has
// had time to finish any trailing work.
module tb;

	// Cycles with no accepted word on any channel before the run is abandoned.
	localparam int QUIET_LIMIT = 2000;
	// Cycles allowed for the back end to settle after the last result word.
	localparam int SETTLE_CYCLES = 40;
	// Random words per phase, nine phases in all.
	localparam int WORDS_PER_PHASE = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cst_pkg::item_t item = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	cst_pkg::result_t result;
	logic result_valid;
	logic result_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [cst_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [cst_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	contrast_stretch_two_pass DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Words waiting to be offered to the block, and the stretched values
	// still owed by it, oldest first.
	cst_pkg::item_t words_to_send[$];
	cst_pkg::result_t stretch_due[$];

	// Our own copy of the block's state and configuration. It is updated
	// only on accepted words.
	logic [7:0] range_low = cst_pkg::OUT_LOW_RESET;
	logic [7:0] range_high = cst_pkg::OUT_HIGH_RESET;
	logic [7:0] seen_min = 8'd255;
	logic [7:0] seen_max = 8'd0;

	// When set, neither side of the data path idles.
	logic steady = 1'b0;
	logic item_taken = 1'b0;

	int faults = 0;
	int quiet = 0;
	int measures = 0;
	int maps = 0;
	int checked = 0;
	int degenerates = 0;
	int cfg_writes = 0;
	int stray_writes = 0;
	int stray_index = 0;
	int stray_value = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Linear mapping of one sample from the measured range onto the output
	// range. The multiply comes first, the quotient truncates toward zero,
	// and the result is clamped between the smaller and larger register.
	function automatic cst_pkg::result_t map_sample(input logic [7:0] v);
		int lo;
		int hi;
		int span;
		int r;
		int bmin;
		int bmax;
		cst_pkg::result_t res;
		lo = int'(range_low);
		hi = int'(range_high);
		span = int'(seen_max) - int'(seen_min);
		res = '0;
		if (span <= 0) begin
			// An empty or reversed measured range forces out_low.
			res.stretched = range_low;
			res.degenerate = 1'b1;
			return res;
		end
		bmin = (lo < hi) ? lo : hi;
		bmax = (lo < hi) ? hi : lo;
		r = (hi - lo) * (int'(v) - int'(seen_min)) / span + lo;
		if (r < bmin) r = bmin;
		if (r > bmax) r = bmax;
		res.stretched = r[7:0];
		res.degenerate = 1'b0;
		return res;
	endfunction

	function automatic cst_pkg::item_t make_word(input logic op, input logic [7:0] s,
		input logic f);
		cst_pkg::item_t w;
		w.op = op;
		w.sample = s;
		w.first = f;
		return w;
	endfunction

	task automatic note_fault(input string msg);
		if (faults < 10) begin
			$display("MISMATCH at %0t: %s", $time, msg);
		end
		faults++;
	endtask

	// Driver. Words and the result ready change on the falling edge. A
	// word that is offered stays put until the block takes it.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			if (words_to_send.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
				item <= words_to_send.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
		result_ready <= arst_n && (steady || $urandom_range(99) >= 35);
	end

	// Monitor. On each rising edge an accepted measure word updates the
	// running minimum and maximum. An accepted map word queues its expected
	// result word, and a delivered result word is checked against the oldest
	// one still owed.
	always @(posedge clk) begin
		cst_pkg::result_t want;
		item_taken <= item_valid && item_ready;
		if (arst_n && item_valid && item_ready) begin
			if (item.op == cst_pkg::OP_MEASURE) begin
				measures++;
				if (item.first) begin
					seen_min = item.sample;
					seen_max = item.sample;
				end else begin
					if (item.sample < seen_min) seen_min = item.sample;
					if (item.sample > seen_max) seen_max = item.sample;
				end
			end else begin
				maps++;
				stretch_due.push_back(map_sample(item.sample));
			end
		end
		if (arst_n && result_valid && result_ready) begin
			if (stretch_due.size() == 0) begin
				note_fault($sformatf(
					"result word with none expected: stretched %0d degenerate %0b",
					result.stretched, result.degenerate));
			end else begin
				want = stretch_due.pop_front();
				checked++;
				if (want.degenerate) degenerates++;
				if (result.stretched !== want.stretched) begin
					note_fault($sformatf("stretched expected %0d got %0d",
						want.stretched, result.stretched));
				end
				if (result.degenerate !== want.degenerate) begin
					note_fault($sformatf("degenerate expected %0b got %0b",
						want.degenerate, result.degenerate));
				end
			end
		end
	end

	// Watchdog. It ends the run if no channel accepts a word for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("Timeout: no word accepted for %0d cycles", QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// One register write. Our copy of the range changes only on an index
	// that the block knows, since other indexes are ignored.
	task automatic write_reg(input logic [cst_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == cst_pkg::REG_OUT_LOW) begin
			range_low = val;
		end else if (idx == cst_pkg::REG_OUT_HIGH) begin
			range_high = val;
		end else begin
			stray_writes++;
		end
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every word went in and every result word came out. Then
	// it gives the back end time to finish, because a trailing measure word
	// owes nothing.
	task automatic drain;
		while (words_to_send.size() != 0 || item_valid || stretch_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One frame, measured and then mapped. The sample spread is sometimes a
	// single value, sometimes narrow and sometimes the full range. Map
	// samples mostly fall inside the measured spread, but a quarter of them
	// land anywhere so that the clamp gets exercised.
	task automatic queue_frame(inout int count);
		int base;
		int spread;
		int n_meas;
		int n_map;
		int s;
		case ($urandom_range(3))
			0: spread = 0;
			1: spread = $urandom_range(1, 8);
			2: spread = $urandom_range(9, 120);
			default: spread = 255;
		endcase
		base = $urandom_range(255 - spread);
		n_meas = $urandom_range(1, 10);
		n_map = $urandom_range(1, 12);
		for (int i = 0; i < n_meas; i++) begin
			s = base + $urandom_range(spread);
			words_to_send.push_back(make_word(cst_pkg::OP_MEASURE, s[7:0], i == 0));
		end
		for (int i = 0; i < n_map; i++) begin
			if ($urandom_range(3) == 0) s = $urandom_range(255);
			else s = base + $urandom_range(spread);
			// The first flag on a map word must not matter.
			words_to_send.push_back(make_word(cst_pkg::OP_MAP, s[7:0],
				1'($urandom_range(1))));
		end
		count += n_meas + n_map;
	endtask

	// A few fully random words. These cover a restart in the middle of a
	// frame, measures without a first word, and maps that arrive before any
	// fresh measurement.
	task automatic queue_noise(inout int count);
		int n;
		n = $urandom_range(1, 5);
		for (int i = 0; i < n; i++) begin
			words_to_send.push_back(make_word(1'($urandom_range(1)),
				8'($urandom_range(255)), 1'($urandom_range(1))));
		end
		count += n;
	endtask

	task automatic queue_random(input int target);
		int count;
		count = 0;
		while (count < target) begin
			if ($urandom_range(9) < 8) queue_frame(count);
			else queue_noise(count);
		end
	endtask

	// Output ranges for the phases after the first one: normal, inverted,
	// collapsed at either end, full downward, and a couple in between.
	logic [7:0] phase_low[8] = '{8'd200, 8'd0, 8'd255, 8'd255, 8'd40, 8'd0, 8'd17, 8'd128};
	logic [7:0] phase_high[8] = '{8'd30, 8'd0, 8'd255, 8'd0, 8'd180, 8'd255, 8'd230, 8'd127};

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words under the reset configuration. Right after reset
		// the measured range is reversed, so every map word is degenerate.
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'd0, 1'b0));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'd255, 1'b1));
		// A single measured value gives an empty range.
		words_to_send.push_back(make_word(cst_pkg::OP_MEASURE, 8'd50, 1'b1));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'd50, 1'b0));
		// Widen the range to 10..200, then map its ends, samples outside it,
		// and a middle sample that carries a first flag, which is ignored.
		words_to_send.push_back(make_word(cst_pkg::OP_MEASURE, 8'd10, 1'b0));
		words_to_send.push_back(make_word(cst_pkg::OP_MEASURE, 8'd200, 1'b0));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'd10, 1'b0));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'd200, 1'b0));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'd0, 1'b0));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'd255, 1'b0));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'd105, 1'b1));
		// The full 0..255 measured range.
		words_to_send.push_back(make_word(cst_pkg::OP_MEASURE, 8'd0, 1'b1));
		words_to_send.push_back(make_word(cst_pkg::OP_MEASURE, 8'd255, 1'b0));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'd128, 1'b0));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'd1, 1'b0));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'd254, 1'b0));
		// A restart at the top of the scale collapses the range again.
		words_to_send.push_back(make_word(cst_pkg::OP_MEASURE, 8'd255, 1'b1));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'd254, 1'b0));
		// Extend downward without a restart, then map alternating bit patterns.
		words_to_send.push_back(make_word(cst_pkg::OP_MEASURE, 8'd0, 1'b0));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'h55, 1'b0));
		words_to_send.push_back(make_word(cst_pkg::OP_MAP, 8'hAA, 1'b0));
		queue_random(WORDS_PER_PHASE - 21);
		drain();

		for (int p = 0; p < 8; p++) begin
			// Phase three runs with no idling on either side.
			steady = (p == 3);
			if (p[0]) begin
				write_reg(cst_pkg::REG_OUT_HIGH, phase_high[p]);
				write_reg(cst_pkg::REG_OUT_LOW, phase_low[p]);
			end else begin
				write_reg(cst_pkg::REG_OUT_LOW, phase_low[p]);
				write_reg(cst_pkg::REG_OUT_HIGH, phase_high[p]);
			end
			// An index outside the register list must leave both alone.
			if (p % 3 == 0) begin
				stray_index = $urandom_range(15, 2);
				stray_value = $urandom_range(255);
				write_reg(stray_index[cst_pkg::CFG_INDEX_BITS-1:0], stray_value[7:0]);
			end
			queue_random(WORDS_PER_PHASE);
			drain();
		end
		steady = 1'b0;

		if (stretch_due.size() != 0) begin
			note_fault($sformatf("%0d result words never arrived", stretch_due.size()));
		end
		$display("Covered %0d measure words and %0d map words; %0d result words checked,",
			measures, maps, checked);
		$display("%0d degenerate; %0d register writes over nine output ranges, %0d to %s",
			degenerates, cfg_writes, stray_writes, "unused indexes");
		if (faults == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
